@@ sv/spp_pkg.sv @@
// Package for the salt and pepper pixel picker.
// Holds widths, defaults, register indexes and tag sizing; no dependencies.
package spp_pkg;

    localparam int MAX_PIXELS_DEF = 65536;
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int ROW_LIMIT      = 256;

    localparam int WORD_W     = 32;
    localparam int DIM_W      = 9;
    localparam int NOISE_W    = 17;
    localparam int COORD_W    = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;
    localparam int PROD_W     = 2 * DIM_W;

    // frame tag kept with each table entry; tag zero marks a cleared entry
    localparam int EPOCH_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_COUNT  = 2'd2;

    localparam logic [DIM_W-1:0]   WIDTH_RST  = 9'd256;
    localparam logic [DIM_W-1:0]   HEIGHT_RST = 9'd256;
    localparam logic [NOISE_W-1:0] NOISE_RST  = 17'd6554;

endpackage

@@ sv/salt_pepper_pixel_picker_core.sv @@
// Salt and pepper pixel picker: top level, the only module.
// Depends on spp_pkg for widths, register indexes and defaults.
//
// Each request (random word plus colour bit) draws one not yet chosen pixel
// of the frame by a partial Fisher-Yates shuffle and returns its column, row,
// salt flag and an end-of-frame flag. One shared restoring divider runs 32
// steps for word mod remaining slots, then IDX_W steps to split the pixel
// index into row and column, with the slot-table accesses S_RD_SLOT,
// S_RD_LAST and S_WRITE between. busy is high in every state but idle;
// a request is taken on a rising edge with start high and busy low. The
// result is flagged by o_valid for exactly one cycle, with no handshake
// to hold it for the receiver. After reset, and after every 2**EPOCH_W - 1
// frames, a clearing pass sweeps all MAX_PIXELS table entries while busy
// stays high. Configuration writes belong between requests (busy low, or
// during the clearing pass) and end the current frame.
module salt_pepper_pixel_picker_core #(
    parameter int MAX_PIXELS = spp_pkg::MAX_PIXELS_DEF,
    parameter int MAX_WIDTH  = spp_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [spp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [spp_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // request
    input  logic                            start,
    output logic                            busy,
    input  logic [spp_pkg::WORD_W-1:0]      i_random_word,
    input  logic                            i_colour_bit,
    // result
    output logic                            o_valid,
    output logic [spp_pkg::COORD_W-1:0]     o_pixel_x,
    output logic [spp_pkg::COORD_W-1:0]     o_pixel_y,
    output logic                            o_is_salt,
    output logic                            o_last_in_frame
);

    localparam int WORD_W  = spp_pkg::WORD_W;
    localparam int IDX_W   = $clog2(MAX_PIXELS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int WX_W    = $clog2(MAX_WIDTH + 1);
    localparam int DEN_W   = (CNT_W > WX_W) ? CNT_W : WX_W;
    localparam int STEP_W  = $clog2(WORD_W + 1);
    localparam int EPOCH_W = spp_pkg::EPOCH_W;
    localparam int ENT_W   = EPOCH_W + IDX_W;

    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
    localparam logic [IDX_W-1:0]   CLR_LAST    = IDX_W'(MAX_PIXELS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SETUP,
        S_DIV_SLOT,
        S_RD_SLOT,
        S_RD_LAST,
        S_WRITE,
        S_DIV_XY
    } t_state;

    t_state r_state;

    // configuration registers
    logic [spp_pkg::DIM_W-1:0]   r_image_width;
    logic [spp_pkg::DIM_W-1:0]   r_image_height;
    logic [spp_pkg::NOISE_W-1:0] r_noise_count;

    // clamped frame geometry, refreshed every cycle
    logic [DEN_W-1:0] r_w_eff;
    logic [CNT_W-1:0] r_pix;
    logic [CNT_W-1:0] r_n_eff;

    logic [CNT_W-1:0]   r_draws;
    logic [EPOCH_W-1:0] r_epoch;
    logic [IDX_W-1:0]   r_clr;

    logic [WORD_W-1:0] r_word;
    logic              r_colour;
    logic [IDX_W-1:0]  r_slot;
    logic [IDX_W-1:0]  r_last;
    logic [IDX_W-1:0]  r_idx;

    // shared divider: remainder, dividend/quotient shifter, divisor, step count
    logic [DEN_W-1:0]  r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [STEP_W-1:0] r_steps;

    // slot table with frame tags
    logic [ENT_W-1:0] r_mem [MAX_PIXELS];
    logic [ENT_W-1:0] r_rdata;

    logic [ENT_W-1:0] mem_wdata;
    logic [IDX_W-1:0] mem_waddr;
    logic             mem_we;
    logic [IDX_W-1:0] mem_raddr;

    logic [spp_pkg::PROD_W-1:0] prod;
    logic [31:0] prod32, pix32, noise32, width32;

    logic [DEN_W:0]   div_t;
    logic             div_ge;
    logic [DEN_W-1:0] n_rem;
    logic [WORD_W-1:0] n_quo;

    logic [CNT_W-1:0] remaining;
    logic [CNT_W-1:0] n_draws;
    logic [IDX_W-1:0] slot_val;
    logic [IDX_W-1:0] last_val;

    // geometry clamps
    always_comb begin
        width32 = 32'(r_image_width);
        if (width32 == 32'd0) begin
            width32 = 32'd1;
        end else if (width32 > 32'(MAX_WIDTH)) begin
            width32 = 32'(MAX_WIDTH);
        end
        prod    = spp_pkg::PROD_W'(width32) * spp_pkg::PROD_W'(
            (r_image_height == '0) ? spp_pkg::DIM_W'(1) :
            (32'(r_image_height) > 32'(spp_pkg::ROW_LIMIT)) ?
                spp_pkg::DIM_W'(spp_pkg::ROW_LIMIT) : r_image_height);
        prod32  = 32'(prod);
        pix32   = (prod32 > 32'(MAX_PIXELS)) ? 32'(MAX_PIXELS) : prod32;
        noise32 = 32'(r_noise_count);
        if (noise32 == 32'd0) begin
            noise32 = 32'd1;
        end else if (noise32 > pix32) begin
            noise32 = pix32;
        end
    end

    // one restoring division step
    always_comb begin
        div_t  = {r_rem, r_quo[WORD_W-1]};
        div_ge = (div_t >= {1'b0, r_den});
        n_rem  = div_ge ? DEN_W'(div_t - {1'b0, r_den}) : div_t[DEN_W-1:0];
        n_quo  = {r_quo[WORD_W-2:0], div_ge};
    end

    // entry resolves to its own slot number unless tagged with this frame
    always_comb begin
        slot_val  = (r_rdata[ENT_W-1:IDX_W] == r_epoch) ? r_rdata[IDX_W-1:0] : r_slot;
        last_val  = (r_rdata[ENT_W-1:IDX_W] == r_epoch) ? r_rdata[IDX_W-1:0] : r_last;
        remaining = r_pix - r_draws;
        n_draws   = r_draws + CNT_W'(1);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_slot;
        mem_wdata = {r_epoch, last_val};
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_waddr = r_clr;
            mem_wdata = '0;
        end else if (r_state == S_WRITE) begin
            mem_we = 1'b1;
        end
        mem_raddr = (r_state == S_RD_SLOT) ? r_slot : r_last;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        r_w_eff <= DEN_W'(width32);
        r_pix   <= CNT_W'(pix32);
        r_n_eff <= CNT_W'(noise32);
        if (!i_rst_n) begin
            r_state         <= S_CLEAR;
            r_clr           <= '0;
            r_epoch         <= EPOCH_FIRST;
            r_draws         <= '0;
            r_image_width   <= spp_pkg::WIDTH_RST;
            r_image_height  <= spp_pkg::HEIGHT_RST;
            r_noise_count   <= spp_pkg::NOISE_RST;
            o_valid         <= 1'b0;
            o_last_in_frame <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + IDX_W'(1);
                    if (r_clr == CLR_LAST) begin
                        r_clr   <= '0;
                        r_epoch <= EPOCH_FIRST;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_word   <= i_random_word;
                        r_colour <= i_colour_bit;
                        r_state  <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_rem   <= '0;
                    r_quo   <= r_word;
                    r_den   <= DEN_W'(remaining);
                    r_last  <= IDX_W'(remaining - CNT_W'(1));
                    r_steps <= STEP_W'(WORD_W);
                    r_state <= S_DIV_SLOT;
                end
                S_DIV_SLOT: begin
                    r_rem   <= n_rem;
                    r_quo   <= n_quo;
                    r_steps <= r_steps - STEP_W'(1);
                    if (r_steps == STEP_W'(1)) begin
                        r_slot  <= IDX_W'(n_rem);
                        r_state <= S_RD_SLOT;
                    end
                end
                S_RD_SLOT: begin
                    r_state <= S_RD_LAST;
                end
                S_RD_LAST: begin
                    r_idx   <= slot_val;
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    // table write happens here; split the index into row, column
                    r_rem   <= '0;
                    r_quo   <= WORD_W'(r_idx) << (WORD_W - IDX_W);
                    r_den   <= r_w_eff;
                    r_steps <= STEP_W'(IDX_W);
                    r_state <= S_DIV_XY;
                end
                S_DIV_XY: begin
                    r_rem   <= n_rem;
                    r_quo   <= n_quo;
                    r_steps <= r_steps - STEP_W'(1);
                    if (r_steps == STEP_W'(1)) begin
                        o_valid         <= 1'b1;
                        o_pixel_x       <= spp_pkg::COORD_W'(n_rem);
                        o_pixel_y       <= spp_pkg::COORD_W'(n_quo);
                        o_is_salt       <= r_colour;
                        o_last_in_frame <= (n_draws == r_n_eff);
                        r_state         <= S_IDLE;
                        if (n_draws == r_n_eff) begin
                            // frame done: retire its tag
                            r_draws <= '0;
                            if (r_epoch == EPOCH_LAST) begin
                                r_state <= S_CLEAR;
                            end else begin
                                r_epoch <= r_epoch + EPOCH_W'(1);
                            end
                        end else begin
                            r_draws <= n_draws;
                        end
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase

            // a write in idle ends the frame; a running sweep already clears all tags
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    spp_pkg::REG_IMAGE_WIDTH: begin
                        r_image_width <= spp_pkg::DIM_W'(i_cfg_data);
                    end
                    spp_pkg::REG_IMAGE_HEIGHT: begin
                        r_image_height <= spp_pkg::DIM_W'(i_cfg_data);
                    end
                    spp_pkg::REG_NOISE_COUNT: begin
                        r_noise_count <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
                r_draws <= '0;
                if (r_state == S_IDLE) begin
                    if (r_epoch == EPOCH_LAST) begin
                        r_state <= S_CLEAR;
                    end else begin
                        r_epoch <= r_epoch + EPOCH_W'(1);
                    end
                end
            end
        end
    end

endmodule

@@ tb/tb_salt_pepper_pixel_picker_core.sv @@
// Testbench for salt_pepper_pixel_picker_core: directed and random draws checked
// against an in-bench partial Fisher-Yates predictor. Depends on spp_pkg and the core.
module tb_salt_pepper_pixel_picker_core;
    timeunit 1ns;
    timeprecision 1ps;

    // index with no register behind it; a write there only ends the frame
    localparam logic [spp_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // slowest run: ~800 requests plus random sender gaps between bursts, plus a full
    // table clear after reset and after every 255 frames
    // (well under a thousand frames here); the limit is several times that
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int SETTLE_TICKS = 64;    // idle ticks after the final drain, before the verdict
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_DRAWS   = 97;
    localparam int DIM_PAD_W     = spp_pkg::CFG_DATA_W - spp_pkg::DIM_W;

    typedef struct {
        logic [spp_pkg::WORD_W-1:0] word;
        logic                       colour;
    } t_draw_request;

    typedef struct packed {
        logic [spp_pkg::COORD_W-1:0] x;
        logic [spp_pkg::COORD_W-1:0] y;
        logic                        salt;
        logic                        frame_end;
    } t_pixel_hit;

    // ------------------------------------------------------------------
    // DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [spp_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [spp_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                           start = 1'b0;
    logic                           busy;
    logic [spp_pkg::WORD_W-1:0]     i_random_word = '0;
    logic                           i_colour_bit = 1'b0;
    logic                           o_valid;
    logic [spp_pkg::COORD_W-1:0]    o_pixel_x;
    logic [spp_pkg::COORD_W-1:0]    o_pixel_y;
    logic                           o_is_salt;
    logic                           o_last_in_frame;

    salt_pepper_pixel_picker_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .start           (start),
        .busy            (busy),
        .i_random_word   (i_random_word),
        .i_colour_bit    (i_colour_bit),
        .o_valid         (o_valid),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_is_salt       (o_is_salt),
        .o_last_in_frame (o_last_in_frame)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Shuffle predictor: own copy of the registers and the frame state.
    // Slots never written this frame read as their own number, so the
    // moved-index map only holds written slots and is emptied per frame.
    // ------------------------------------------------------------------
    logic [spp_pkg::DIM_W-1:0]   shadow_width  = spp_pkg::WIDTH_RST;
    logic [spp_pkg::DIM_W-1:0]   shadow_height = spp_pkg::HEIGHT_RST;
    logic [spp_pkg::NOISE_W-1:0] shadow_noise  = spp_pkg::NOISE_RST;
    int unsigned                 frame_draws   = 0;
    int unsigned                 moved_index [int unsigned];

    t_draw_request pending_requests[$];
    t_pixel_hit    pending_pixels[$];

    int unsigned mismatches  = 0;
    int unsigned cycle_count = 0;

    function automatic int unsigned clamp_range(int unsigned v, int unsigned lo,
                                                int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned live_width();
        return clamp_range(shadow_width, 1, spp_pkg::MAX_WIDTH_DEF);
    endfunction

    function automatic int unsigned frame_pixels();
        int unsigned p;
        p = live_width() * clamp_range(shadow_height, 1, spp_pkg::ROW_LIMIT);
        return (p > spp_pkg::MAX_PIXELS_DEF) ? spp_pkg::MAX_PIXELS_DEF : p;
    endfunction

    function automatic void restart_frame();
        frame_draws = 0;
        moved_index.delete();
    endfunction

    function automatic int unsigned slot_content(int unsigned s);
        return moved_index.exists(s) ? moved_index[s] : s;
    endfunction

    // one draw: pick a live slot, report its pixel, fold the last live slot in
    function automatic void draw_pixel(logic [spp_pkg::WORD_W-1:0] word, logic colour);
        int unsigned w, pixels, n, remaining, slot, pix;
        t_pixel_hit  hit;
        w         = live_width();
        pixels    = frame_pixels();
        n         = clamp_range(shadow_noise, 1, pixels);
        if (frame_draws >= n) restart_frame();
        remaining = pixels - frame_draws;
        slot      = word % remaining;
        pix       = slot_content(slot);
        moved_index[slot] = slot_content(remaining - 1);
        frame_draws++;
        hit.x         = spp_pkg::COORD_W'(pix % w);
        hit.y         = spp_pkg::COORD_W'(pix / w);
        hit.salt      = colour;
        hit.frame_end = (frame_draws == n);
        if (hit.frame_end) restart_frame();
        pending_pixels.push_back(hit);
    endfunction

    function automatic void apply_reg_write(logic [spp_pkg::CFG_IDX_W-1:0] idx,
                                            logic [spp_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            spp_pkg::REG_IMAGE_WIDTH:  shadow_width  = data[spp_pkg::DIM_W-1:0];
            spp_pkg::REG_IMAGE_HEIGHT: shadow_height = data[spp_pkg::DIM_W-1:0];
            spp_pkg::REG_NOISE_COUNT:  shadow_noise  = data[spp_pkg::NOISE_W-1:0];
            default: ;
        endcase
        restart_frame();   // any write, known index or not, ends the frame
    endfunction

    // ------------------------------------------------------------------
    // Request driver: bursts of random length, random gaps between them.
    // Prediction happens at the edge that takes the request.
    // ------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin : request_driver
        logic          taken;
        logic          start_next;
        t_draw_request req;
        if (!i_rst_n) begin
            start      <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            taken      = start && !busy;
            start_next = start;
            if (taken) draw_pixel(i_random_word, i_colour_bit);
            if (!start || taken) begin
                start_next = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_requests.size() > 0) begin
                    req = pending_requests.pop_front();
                    i_random_word <= req.word;
                    i_colour_bit  <= req.colour;
                    start_next    = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        // new burst; the gap lands on a random point of the draw
                        burst_left = $urandom_range(1, 12);
                        case ($urandom_range(0, 3))
                            0:       gap_left = 0;
                            1:       gap_left = $urandom_range(1, 8);
                            2:       gap_left = $urandom_range(20, 90);
                            default: gap_left = 0;
                        endcase
                    end
                end
            end
            start <= start_next;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: one-cycle strobe, compared with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_monitor
        t_pixel_hit want;
        t_pixel_hit got;
        if (i_rst_n && o_valid) begin
            got = '{o_pixel_x, o_pixel_y, o_is_salt, o_last_in_frame};
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected result x=%0d y=%0d salt=%0b last=%0b",
                             $realtime, got.x, got.y, got.salt, got.frame_end);
            end else begin
                want = pending_pixels.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $write("[%0t] mismatch: exp x=%0d y=%0d salt=%0b last=%0b, ",
                               $realtime, want.x, want.y, want.salt, want.frame_end);
                        $display("got x=%0d y=%0d salt=%0b last=%0b",
                                 got.x, got.y, got.salt, got.frame_end);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    task automatic queue_draw(logic [spp_pkg::WORD_W-1:0] word, logic colour);
        t_draw_request req;
        req.word   = word;
        req.colour = colour;
        pending_requests.push_back(req);
    endtask

    // wait for every request to be taken and every result to come back
    task automatic drain();
        do @(negedge i_clk);
        while (pending_requests.size() != 0 || start || pending_pixels.size() != 0);
    endtask

    task automatic write_reg(logic [spp_pkg::CFG_IDX_W-1:0] idx,
                             logic [spp_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        apply_reg_write(idx, data);
    endtask

    task automatic set_frame(logic [spp_pkg::CFG_DATA_W-1:0] w,
                             logic [spp_pkg::CFG_DATA_W-1:0] h,
                             logic [spp_pkg::CFG_DATA_W-1:0] n);
        write_reg(spp_pkg::REG_IMAGE_WIDTH, w);
        write_reg(spp_pkg::REG_IMAGE_HEIGHT, h);
        write_reg(spp_pkg::REG_NOISE_COUNT, n);
    endtask

    // dimension with random bits above the 9-bit register
    function automatic logic [spp_pkg::CFG_DATA_W-1:0] random_dim();
        logic [spp_pkg::DIM_W-1:0] d;
        case ($urandom_range(0, 7))
            0:       d = spp_pkg::DIM_W'(1);
            1:       d = spp_pkg::DIM_W'($urandom_range(257, 511));   // clamps to 256
            2:       d = spp_pkg::DIM_W'($urandom_range(17, 256));
            3:       d = '0;                                           // taken as 1
            default: d = spp_pkg::DIM_W'($urandom_range(2, 16));
        endcase
        return {DIM_PAD_W'($urandom_range(0, 255)), d};
    endfunction

    function automatic logic [spp_pkg::CFG_DATA_W-1:0] random_noise(int unsigned pixels);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return spp_pkg::CFG_DATA_W'(pixels);
            2:       return spp_pkg::CFG_DATA_W'(
                         $urandom_range(pixels, (1 << spp_pkg::NOISE_W) - 1));
            default: return spp_pkg::CFG_DATA_W'(
                         $urandom_range(1, (pixels < 64) ? pixels : 64));
        endcase
    endfunction

    function automatic logic [spp_pkg::WORD_W-1:0] random_word(int unsigned pixels);
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 2 * pixels);
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults: 256x256, extremes of the random word
        queue_draw('0, 1'b1);
        queue_draw('1, 1'b0);
        queue_draw(32'd65533, 1'b1);        // picks the last live slot
        queue_draw(32'h8000_0000, 1'b0);
        drain();

        // single-pixel frame: every draw is the last one
        set_frame(17'd1, 17'd1, 17'd1);
        queue_draw('1, 1'b1);
        queue_draw('0, 1'b0);
        drain();

        // zero width, height and count all taken as 1
        set_frame('0, '0, '0);
        queue_draw(32'h5A5A_A5A5, 1'b1);
        queue_draw(32'hA5A5_5A5A, 1'b0);
        drain();

        // 3x2 frame drawn out completely, then into the next frame
        set_frame(17'd3, 17'd2, 17'd6);
        repeat (8) queue_draw($urandom(), 1'($urandom_range(0, 1)));
        drain();
        // write to the unused index ends the second frame after two of its six draws
        write_reg(REG_UNUSED, '1);
        repeat (3) queue_draw($urandom(), 1'($urandom_range(0, 1)));
        drain();

        // oversized width and count: one row of 256, full frame count
        set_frame('1, 17'd1, '1);
        queue_draw('1, 1'b1);
        queue_draw(32'd255, 1'b0);
        queue_draw('0, 1'b1);
        drain();

        // one column of 256 rows
        set_frame(17'd1, '1, 17'd2);
        queue_draw(32'd255, 1'b1);
        queue_draw('1, 1'b0);
        drain();

        // random frames with random content
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_reg(spp_pkg::REG_IMAGE_WIDTH, random_dim());
            write_reg(spp_pkg::REG_IMAGE_HEIGHT, random_dim());
            write_reg(spp_pkg::REG_NOISE_COUNT, random_noise(frame_pixels()));
            for (int k = 0; k < PHASE_DRAWS; k++) begin
                queue_draw(random_word(frame_pixels()), 1'($urandom_range(0, 1)));
                // now and then a stray write cuts a frame short
                if (k == PHASE_DRAWS / 2 && $urandom_range(0, 2) == 0) begin
                    drain();
                    write_reg(REG_UNUSED, spp_pkg::CFG_DATA_W'($urandom()));
                end
            end
            drain();
        end

        drain();
        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
